>>> rtl/lcal_pkg.sv
// Shared constants, datapath operation codes and controller/datapath status for the LCA engine.
`default_nettype none

package lcal_pkg;

	// Node ids are 10 bits and every id maps onto a table row.
	localparam int NODE_W     = 10;
	localparam int NODES      = 1 << NODE_W;
	localparam int NODE_IDX_W = $clog2(NODES);
	localparam int DEPTH_W    = 10;
	localparam int LEVELS_DEF = 11;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(NODES - 1);

	// Operation the controller asks of the datapath in the current cycle.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_A_RD,
		OP_A_FILL,
		OP_A_WR,
		OP_Q_RD,
		OP_Q_ORD,
		OP_Q_LIFT,
		OP_Q_CMP,
		OP_Q_CLIMB,
		OP_Q_FIN,
		OP_PUSH
	} dp_op_t;

	// Status the datapath reports back to the controller.
	typedef struct packed {
		logic node_zero;
		logic parent_zero;
		logic same;
		logic clear_last;
		logic slot_free;
	} dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/lcal_if.sv
// Valid/ready channel interfaces for the request and response sides of the LCA engine.
`default_nettype none

interface lcal_req_if;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [lcal_pkg::NODE_W-1:0] node_a;
	logic [lcal_pkg::NODE_W-1:0] node_b;

	modport source (output valid, kind, node_a, node_b, input ready);
	modport sink (input valid, kind, node_a, node_b, output ready);
endinterface

interface lcal_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [lcal_pkg::NODE_W-1:0] ancestor;

	modport source (output valid, ancestor, input ready);
	modport sink (input valid, ancestor, output ready);
endinterface

`default_nettype wire

>>> rtl/lcal_dp.sv
// Datapath of the LCA engine: the ancestor/depth row memory, walk registers and result register.
`default_nettype none

module lcal_dp #(
	parameter int LEVELS = lcal_pkg::LEVELS_DEF,
	localparam int LEV_W = $clog2(LEVELS)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lcal_pkg::dp_op_t              op,
	input  wire logic [LEV_W-1:0]              lev,
	input  wire logic [lcal_pkg::NODE_W-1:0]   node_a,
	input  wire logic [lcal_pkg::NODE_W-1:0]   node_b,
	output lcal_pkg::dp_sts_t                  sts,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic [lcal_pkg::NODE_W-1:0]        out_ancestor
);

	// One row per node: its depth and its 2^j ancestors.
	typedef struct packed {
		logic [lcal_pkg::DEPTH_W-1:0]             depth;
		logic [LEVELS-1:0][lcal_pkg::NODE_W-1:0]  anc;
	} row_t;

	row_t row_mem_q [lcal_pkg::NODES];
	row_t rd_a_q;
	row_t rd_b_q;
	row_t row_q;

	logic [lcal_pkg::NODE_W-1:0]     a_q, b_q, cur_q, res_q, out_anc_q;
	logic [lcal_pkg::DEPTH_W-1:0]    diff_q;
	logic [lcal_pkg::NODE_IDX_W-1:0] clr_cnt_q;
	logic                            out_vld_q;

	logic [lcal_pkg::NODE_W-1:0] addr_a, addr_b, a_nx, b_nx, cur_nx, lvl_a, lvl_b;
	logic                        swap;
	logic                        mem_we;
	logic [lcal_pkg::NODE_W-1:0] mem_wa;
	row_t                        mem_wd;

	assign swap  = rd_a_q.depth < rd_b_q.depth;
	assign lvl_a = rd_a_q.anc[lev];
	assign lvl_b = rd_b_q.anc[lev];

	// Read addresses follow the next value of each walk register (OP_A_RD reads
	// the parent), so the registered read data holds the row of the current node.
	always_comb begin
		addr_a = a_q;
		addr_b = b_q;
		a_nx   = a_q;
		b_nx   = b_q;
		cur_nx = cur_q;
		case (op)
			lcal_pkg::OP_A_RD: begin
				addr_a = b_q;
			end
			lcal_pkg::OP_A_FILL: begin
				// A hop that lands on the node being attached sees its new entry.
				cur_nx = (cur_q == a_q) ? a_q : rd_a_q.anc[lev - LEV_W'(1)];
				addr_a = cur_nx;
			end
			lcal_pkg::OP_Q_ORD: begin
				if (swap) begin
					addr_a = b_q;
					addr_b = a_q;
				end
			end
			lcal_pkg::OP_Q_LIFT: begin
				if (diff_q[0]) begin
					a_nx = lvl_a;
				end
				addr_a = a_nx;
			end
			lcal_pkg::OP_Q_CLIMB: begin
				if (lvl_a != lvl_b) begin
					a_nx = lvl_a;
					b_nx = lvl_b;
				end
				addr_a = a_nx;
				addr_b = b_nx;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = a_q;
		mem_wd = row_q;
		case (op)
			lcal_pkg::OP_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_cnt_q;
				mem_wd = '0;
			end
			lcal_pkg::OP_A_WR: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			row_mem_q[mem_wa] <= mem_wd;
		end
		rd_a_q <= row_mem_q[addr_a];
		rd_b_q <= row_mem_q[addr_b];
	end

	always_ff @(posedge clk) begin
		case (op)
			lcal_pkg::OP_LOAD: begin
				a_q <= node_a;
				b_q <= node_b;
			end
			lcal_pkg::OP_A_RD: begin
				cur_q <= b_q;
				// A fresh row holds only the parent; depth comes with the first fill.
				row_q <= {{lcal_pkg::DEPTH_W{1'b0}},
					{((LEVELS - 1) * lcal_pkg::NODE_W){1'b0}}, b_q};
			end
			lcal_pkg::OP_A_FILL: begin
				cur_q <= cur_nx;
				row_q.anc[lev] <= cur_nx;
				if (lev == LEV_W'(1)) begin
					row_q.depth <= (rd_a_q.depth >= lcal_pkg::DEPTH_MAX) ?
						lcal_pkg::DEPTH_MAX : rd_a_q.depth + lcal_pkg::DEPTH_W'(1);
				end
			end
			lcal_pkg::OP_Q_ORD: begin
				if (swap) begin
					a_q    <= b_q;
					b_q    <= a_q;
					diff_q <= rd_b_q.depth - rd_a_q.depth;
				end else begin
					diff_q <= rd_a_q.depth - rd_b_q.depth;
				end
			end
			lcal_pkg::OP_Q_LIFT: begin
				a_q    <= a_nx;
				diff_q <= diff_q >> 1;
			end
			lcal_pkg::OP_Q_CMP: begin
				res_q <= a_q;
			end
			lcal_pkg::OP_Q_CLIMB: begin
				a_q <= a_nx;
				b_q <= b_nx;
			end
			lcal_pkg::OP_Q_FIN: begin
				res_q <= rd_a_q.anc[0];
			end
			lcal_pkg::OP_PUSH: begin
				out_anc_q <= res_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (op == lcal_pkg::OP_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + lcal_pkg::NODE_IDX_W'(1);
			end
			if (op == lcal_pkg::OP_PUSH) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign sts.node_zero   = (a_q == '0);
	assign sts.parent_zero = (b_q == '0);
	assign sts.same        = (a_q == b_q);
	assign sts.clear_last  = (clr_cnt_q == lcal_pkg::NODE_IDX_W'(lcal_pkg::NODES - 1));
	assign sts.slot_free   = !out_vld_q || out_ready;

	assign out_valid    = out_vld_q;
	assign out_ancestor = out_anc_q;

endmodule

`default_nettype wire

>>> rtl/lcal_ctrl.sv
// Controller state machine of the LCA engine: sequences clearing, attach and query walks.
`default_nettype none

module lcal_ctrl #(
	parameter int LEVELS = lcal_pkg::LEVELS_DEF,
	localparam int LEV_W = $clog2(LEVELS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              req_kind,
	output logic                   req_ready,
	input  wire lcal_pkg::dp_sts_t sts,
	output lcal_pkg::dp_op_t       op,
	output logic [LEV_W-1:0]       lev
);

	typedef enum logic [11:0] {
		S_CLEAR   = 12'b0000_0000_0001,
		S_IDLE    = 12'b0000_0000_0010,
		S_A_RD    = 12'b0000_0000_0100,
		S_A_FILL  = 12'b0000_0000_1000,
		S_A_WR    = 12'b0000_0001_0000,
		S_Q_RD    = 12'b0000_0010_0000,
		S_Q_ORD   = 12'b0000_0100_0000,
		S_Q_LIFT  = 12'b0000_1000_0000,
		S_Q_CMP   = 12'b0001_0000_0000,
		S_Q_CLIMB = 12'b0010_0000_0000,
		S_Q_FIN   = 12'b0100_0000_0000,
		S_DONE    = 12'b1000_0000_0000
	} state_t;

	localparam logic [LEV_W-1:0] LEV_TOP = LEV_W'(LEVELS - 1);

	state_t           state_q, state_nx;
	logic [LEV_W-1:0] lev_q, lev_nx;

	always_comb begin
		state_nx  = state_q;
		lev_nx    = lev_q;
		op        = lcal_pkg::OP_NONE;
		req_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				op = lcal_pkg::OP_CLEAR;
				if (sts.clear_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					op       = lcal_pkg::OP_LOAD;
					state_nx = req_kind ? S_Q_RD : S_A_RD;
				end
			end
			S_A_RD: begin
				op = lcal_pkg::OP_A_RD;
				if (sts.node_zero) begin
					state_nx = S_IDLE;
				end else if (sts.parent_zero) begin
					state_nx = S_A_WR;
				end else begin
					state_nx = S_A_FILL;
					lev_nx   = LEV_W'(1);
				end
			end
			S_A_FILL: begin
				op = lcal_pkg::OP_A_FILL;
				if (lev_q == LEV_TOP) begin
					state_nx = S_A_WR;
				end else begin
					lev_nx = lev_q + LEV_W'(1);
				end
			end
			S_A_WR: begin
				op       = lcal_pkg::OP_A_WR;
				state_nx = S_IDLE;
			end
			S_Q_RD: begin
				op       = lcal_pkg::OP_Q_RD;
				state_nx = S_Q_ORD;
			end
			S_Q_ORD: begin
				op       = lcal_pkg::OP_Q_ORD;
				state_nx = S_Q_LIFT;
				lev_nx   = '0;
			end
			S_Q_LIFT: begin
				op = lcal_pkg::OP_Q_LIFT;
				if (lev_q == LEV_TOP) begin
					state_nx = S_Q_CMP;
				end else begin
					lev_nx = lev_q + LEV_W'(1);
				end
			end
			S_Q_CMP: begin
				op = lcal_pkg::OP_Q_CMP;
				if (sts.same) begin
					state_nx = S_DONE;
				end else begin
					state_nx = S_Q_CLIMB;
					lev_nx   = LEV_TOP;
				end
			end
			S_Q_CLIMB: begin
				op = lcal_pkg::OP_Q_CLIMB;
				if (lev_q == '0) begin
					state_nx = S_Q_FIN;
				end else begin
					lev_nx = lev_q - LEV_W'(1);
				end
			end
			S_Q_FIN: begin
				op       = lcal_pkg::OP_Q_FIN;
				state_nx = S_DONE;
			end
			S_DONE: begin
				if (sts.slot_free) begin
					op       = lcal_pkg::OP_PUSH;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			lev_q   <= '0;
		end else begin
			state_q <= state_nx;
			lev_q   <= lev_nx;
		end
	end

	assign lev = lev_q;

endmodule

`default_nettype wire

>>> rtl/lowest_common_ancestor_lifting.sv
// Top level of the binary-lifting lowest-common-ancestor engine.
//
//   channel | dir | beat payload             | meaning
//   --------+-----+--------------------------+-----------------------------------------
//   req     | in  | kind, node_a, node_b     | kind 0: attach node_a under node_b
//           |     |                          | kind 1: query the LCA of node_a, node_b
//   rsp     | out | ancestor                 | one beat per query, none per attach
//
// After reset the engine clears its row memory (NODES, 1024 rows) and takes
// no request beat until that pass ends. An attach fills the new row one
// ancestor level at a time (a root has none, node 0 is dropped), and a query
// lifts the deeper node and climbs both unless they meet. Each step waits on
// a dependent read of the row memory. One beat is worked on at a time; a
// finished answer waits in the response register, so a stalled rsp side only holds
// the engine when a second answer is ready before the first has been taken.
`default_nettype none

module lowest_common_ancestor_lifting #(
	parameter int LEVELS = lcal_pkg::LEVELS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lcal_req_if.sink  req,
	lcal_rsp_if.source rsp
);

	localparam int LEV_W = $clog2(LEVELS);

	// Controller and datapath talk only through the operation code, the level
	// counter and the status bundle.
	lcal_pkg::dp_op_t  op;
	lcal_pkg::dp_sts_t sts;
	logic [LEV_W-1:0]  lev;

	lcal_ctrl #(
		.LEVELS(LEVELS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_kind (req.kind),
		.req_ready(req.ready),
		.sts      (sts),
		.op       (op),
		.lev      (lev)
	);

	// The datapath holds the row memory (depth plus all 2^j ancestors per
	// node), the walk registers and the response register.
	lcal_dp #(
		.LEVELS(LEVELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.lev         (lev),
		.node_a      (req.node_a),
		.node_b      (req.node_b),
		.sts         (sts),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.out_ancestor(rsp.ancestor)
	);

endmodule

`default_nettype wire

>>> bench/lowest_common_ancestor_lifting_test.sv
// Self-checking testbench for the binary-lifting lowest-common-ancestor engine.
`default_nettype none

module lowest_common_ancestor_lifting_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Codes carried in the kind field of a request beat.
	localparam logic KIND_ATTACH = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	localparam int LEVELS       = lcal_pkg::LEVELS_DEF;
	localparam int RESET_CYCLES = 11;
	// The last stretch of requests runs with no idling on either side.
	localparam int TAIL_ITEMS   = 130;
	// Slowest correct run: about 1800 beats, each at worst a full query plus an
	// idle gap and a response stall, after the clearing pass.
	// The limit is several times that.
	localparam int LIMIT_CYCLES = 400000;
	// Nodes on the deep chain, and attaches that bounce between two nodes on
	// top of it until the depth saturates.
	localparam int CHAIN_LEN    = 560;
	localparam int BOUNCES      = 500;

	typedef logic [lcal_pkg::NODE_W-1:0] node_t;

	typedef struct {
		logic  kind;
		node_t node_a;
		node_t node_b;
		bit    hold;   // wait until every owed answer has come back
	} request_t;

	logic clk = 1'b0;
	logic arst_n;

	lcal_req_if req_ch ();
	lcal_rsp_if rsp_ch ();

	lowest_common_ancestor_lifting #(.LEVELS(LEVELS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #1 clk = ~clk;

	// Predicted engine state: the 2^j-th ancestor of each node and its depth.
	node_t                        jump [LEVELS][lcal_pkg::NODES];
	logic [lcal_pkg::DEPTH_W-1:0] depth_of [lcal_pkg::NODES];

	request_t pending [$];       // request beats not yet taken by the engine
	node_t    ancestors_due [$]; // answers owed, oldest first
	node_t    grown [$];         // nodes the stimulus has attached so far

	int unsigned cycle_count;
	int          mismatches;
	int          attaches_taken;
	int          queries_taken;
	int          answers_checked;
	int          sentinel_answers;
	int          deepest;
	bit          quiet_tail;

	// Sender and receiver pacing.
	int       gap_in;
	int       stall_out;
	bit       steady_in;
	bit       steady_out;
	bit       send;
	request_t head;
	node_t    want;

	// Attach: copy the parent's ancestor rows into the new node's row, one level
	// at a time, and put the node one below its parent. A root gets an all-zero
	// row. Node 0 is the sentinel and is never written.
	function automatic void graft(node_t node, node_t parent);
		int j;
		if (node == '0)
			return;
		if (parent == '0) begin
			for (j = 0; j < LEVELS; j++)
				jump[j][node] = '0;
			depth_of[node] = '0;
			return;
		end
		jump[0][node] = parent;
		for (j = 1; j < LEVELS; j++)
			jump[j][node] = jump[j-1][jump[j-1][node]];
		// Re-attaching under a descendant makes a loop; depth stops at the top.
		if (depth_of[parent] >= lcal_pkg::DEPTH_MAX)
			depth_of[node] = lcal_pkg::DEPTH_MAX;
		else
			depth_of[node] = depth_of[parent] + 1'b1;
	endfunction

	// Query: bring the deeper node up to the other's depth, then climb both
	// from the highest level down while their ancestors still differ.
	function automatic node_t meet(node_t a, node_t b);
		node_t       x;
		node_t       y;
		node_t       t;
		logic [31:0] climb;
		int          j;
		x = a;
		y = b;
		if (depth_of[x] < depth_of[y]) begin
			t = x;
			x = y;
			y = t;
		end
		climb = 32'(depth_of[x]) - 32'(depth_of[y]);
		for (j = 0; j < LEVELS; j++)
			if (climb[j])
				x = jump[j][x];
		if (x == y)
			return x;
		for (j = LEVELS - 1; j >= 0; j--) begin
			if (jump[j][x] != jump[j][y]) begin
				x = jump[j][x];
				y = jump[j][y];
			end
		end
		return jump[0][x];
	endfunction

	task automatic add_item(logic kind, node_t a, node_t b, bit hold = 1'b0);
		request_t r;
		r.kind   = kind;
		r.node_a = a;
		r.node_b = b;
		r.hold   = hold;
		pending.insert(pending.size(), r);
		if (kind == KIND_ATTACH && a != '0)
			grown.insert(grown.size(), a);
	endtask

	function automatic node_t pick_grown();
		if (grown.size() == 0)
			return node_t'($urandom_range(1, lcal_pkg::NODES - 1));
		return grown[$urandom_range(0, grown.size() - 1)];
	endfunction

	// Mostly well-formed tree building and queries on attached nodes, with some
	// roots, orphans, re-attaches, sentinel touches and arbitrary ids mixed in.
	task automatic mixed_items(int count, bit hold_first);
		int    k;
		int    roll;
		node_t a;
		node_t b;
		for (k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				a = node_t'($urandom_range(1, lcal_pkg::NODES - 1));
				roll = $urandom_range(0, 9);
				if (roll == 0)
					b = '0;
				else if (roll == 1)
					b = node_t'($urandom);
				else
					b = pick_grown();
				add_item(KIND_ATTACH, a, b, hold_first && k == 0);
			end else if (roll < 90) begin
				if ($urandom_range(0, 6) == 0) begin
					a = node_t'($urandom);
					b = node_t'($urandom);
				end else begin
					a = pick_grown();
					b = pick_grown();
				end
				add_item(KIND_QUERY, a, b, hold_first && k == 0);
			end else if (roll < 95) begin
				add_item(KIND_ATTACH, '0, node_t'($urandom), hold_first && k == 0);
			end else begin
				add_item(KIND_QUERY, '0, pick_grown(), hold_first && k == 0);
			end
		end
	endtask

	// Reset, stimulus and end of run.
	initial begin
		node_t order [lcal_pkg::NODES-1];
		node_t t;
		node_t top_p;
		node_t top_q;
		int    i;
		int    j;
		int    k;

		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.kind   = KIND_ATTACH;
		req_ch.node_a = '0;
		req_ch.node_b = '0;
		rsp_ch.ready  = 1'b0;
		for (i = 0; i < lcal_pkg::NODES; i++) begin
			depth_of[i] = '0;
			for (j = 0; j < LEVELS; j++)
				jump[j][i] = '0;
		end

		// Directed opening: a small tree with the largest id at its bottom.
		add_item(KIND_ATTACH, 10'd1, 10'd0);
		add_item(KIND_ATTACH, 10'd2, 10'd1);
		add_item(KIND_ATTACH, 10'd3, 10'd1);
		add_item(KIND_ATTACH, 10'd4, 10'd2);
		add_item(KIND_ATTACH, 10'd1023, 10'd4);
		add_item(KIND_QUERY, 10'd4, 10'd3);       // siblings' subtrees meet at 1
		add_item(KIND_QUERY, 10'd1023, 10'd3);    // deeper node lifted first
		add_item(KIND_QUERY, 10'd1023, 10'd1023); // same node
		add_item(KIND_QUERY, 10'd4, 10'd1023);    // one is an ancestor of the other
		add_item(KIND_ATTACH, 10'd0, 10'd1);      // the sentinel cannot be attached
		add_item(KIND_QUERY, 10'd0, 10'd4);
		add_item(KIND_ATTACH, 10'd5, 10'd0);      // a second root
		add_item(KIND_QUERY, 10'd5, 10'd1023);    // different trees end at the sentinel
		add_item(KIND_QUERY, 10'd600, 10'd601);   // neither node was ever attached
		add_item(KIND_ATTACH, 10'd6, 10'd700);    // parent never attached
		add_item(KIND_QUERY, 10'd6, 10'd700);
		add_item(KIND_QUERY, 10'd6, 10'd5);
		// Moving node 2 leaves its old children with their stale rows.
		add_item(KIND_ATTACH, 10'd2, 10'd5, 1'b1);
		add_item(KIND_QUERY, 10'd4, 10'd2);
		add_item(KIND_QUERY, 10'd1023, 10'd5);
		// Putting 3 under 1023 moves it below a node whose rows are stale.
		add_item(KIND_ATTACH, 10'd3, 10'd1023);
		add_item(KIND_QUERY, 10'd3, 10'd1);
		add_item(KIND_QUERY, 10'd1022, 10'd512);

		mixed_items(280, 1'b1);

		// A deep chain through shuffled ids, queried at random pairs on the way,
		// so the depth difference uses every lift level the depths can reach.
		for (i = 0; i < lcal_pkg::NODES - 1; i++)
			order[i] = node_t'(i + 1);
		for (i = lcal_pkg::NODES - 2; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		add_item(KIND_ATTACH, order[0], '0, 1'b1);
		for (i = 1; i < CHAIN_LEN; i++) begin
			add_item(KIND_ATTACH, order[i], order[i-1]);
			if ($urandom_range(0, 2) == 0) begin
				if ($urandom_range(0, 3) == 0)
					add_item(KIND_QUERY, order[i], pick_grown());
				else
					add_item(KIND_QUERY, order[$urandom_range(0, i)],
						order[$urandom_range(0, i)]);
			end
		end

		// Two nodes re-attached under each other in turn on top of the chain:
		// each attach goes one deeper until the depth saturates.
		top_p = order[CHAIN_LEN];
		top_q = order[CHAIN_LEN + 1];
		add_item(KIND_ATTACH, top_p, order[CHAIN_LEN - 1], 1'b1);
		for (k = 0; k < BOUNCES; k++) begin
			if (k % 2 == 0)
				add_item(KIND_ATTACH, top_q, top_p);
			else
				add_item(KIND_ATTACH, top_p, top_q);
			if (k % 8 == 7) begin
				add_item(KIND_QUERY, top_p, order[$urandom_range(0, CHAIN_LEN - 1)]);
				add_item(KIND_QUERY, top_q, top_p);
			end
		end

		mixed_items(TAIL_ITEMS, 1'b1);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending.size() != 0 || ancestors_due.size() != 0 || req_ch.valid);
		// Let any stray answer show up before the verdict.
		repeat (2 * LEVELS + 20) @(posedge clk);

		$display("Took %0d attaches and %0d queries; %0d answers checked, %0d at the sentinel.",
			attaches_taken, queries_taken, answers_checked, sentinel_answers);
		$display("Deepest predicted node depth was %0d of a possible %0d.", deepest,
			lcal_pkg::DEPTH_MAX);
		if (mismatches == 0)
			$display("lowest_common_ancestor_lifting_test: clean");
		else
			$display("lowest_common_ancestor_lifting_test: errors");
		$finish;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES)
			@(posedge clk);
		$display("Timed out after %0d cycles with %0d beats unsent and %0d answers owed.",
			cycle_count, pending.size(), ancestors_due.size());
		$display("lowest_common_ancestor_lifting_test: errors");
		$finish;
	end

	// Request driver. A beat that is up stays up until the engine takes it; the
	// prediction is made at the edge where it is taken. Idle bursts start only
	// between beats, and a beat marked hold waits for all answers to drain.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			gap_in = 0;
			steady_in = 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				head = pending.pop_front();
				if (head.kind == KIND_QUERY) begin
					want = meet(head.node_a, head.node_b);
					ancestors_due.insert(ancestors_due.size(), want);
					queries_taken++;
				end else begin
					graft(head.node_a, head.node_b);
					if (int'(depth_of[head.node_a]) > deepest)
						deepest = int'(depth_of[head.node_a]);
					attaches_taken++;
				end
				// Now and then switch to a stretch with no idling.
				if ((attaches_taken + queries_taken) % 100 == 0)
					steady_in = ($urandom_range(0, 3) == 0);
			end
			quiet_tail = (pending.size() <= TAIL_ITEMS);
			if (!(req_ch.valid && !req_ch.ready)) begin
				send = 1'b0;
				if (gap_in > 0)
					gap_in--;
				else if (pending.size() != 0 &&
					!(pending[0].hold && ancestors_due.size() != 0)) begin
					if (!steady_in && !quiet_tail && $urandom_range(0, 4) == 0)
						gap_in = $urandom_range(0, 6);
					else
						send = 1'b1;
				end
				req_ch.valid <= send;
				if (send) begin
					req_ch.kind   <= pending[0].kind;
					req_ch.node_a <= pending[0].node_a;
					req_ch.node_b <= pending[0].node_b;
				end
			end
		end
	end

	// Response monitor and ready pacing. Every answer beat is checked against
	// the oldest owed answer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_out = 0;
			steady_out = 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (ancestors_due.size() == 0) begin
					$display("%0t: answer %0d arrived with none owed (expected nothing)",
						$time, rsp_ch.ancestor);
					mismatches++;
				end else begin
					want = ancestors_due.pop_front();
					if (rsp_ch.ancestor !== want) begin
						$display("%0t: ancestor mismatch: expected %0d, actual %0d",
							$time, want, rsp_ch.ancestor);
						mismatches++;
					end
					if (want == '0)
						sentinel_answers++;
					answers_checked++;
					if (answers_checked % 40 == 0)
						steady_out = ($urandom_range(0, 3) == 0);
				end
			end
			if (stall_out > 0) begin
				stall_out--;
				rsp_ch.ready <= 1'b0;
			end else if (!steady_out && !quiet_tail && $urandom_range(0, 4) == 0) begin
				stall_out = $urandom_range(0, 6);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire
